@@ rtl/bap_pkg.sv @@
// Shared types and constants of the advertising record parser.
// No dependencies; bap_core, bap_res_fifo and the top level import this package.
package bap_pkg;

  // Advertising data record types
  localparam logic [7:0] AD_FLAGS        = 8'h01;
  localparam logic [7:0] AD_UUID16_PART  = 8'h02;
  localparam logic [7:0] AD_UUID16_FULL  = 8'h03;
  localparam logic [7:0] AD_UUID32_PART  = 8'h04;
  localparam logic [7:0] AD_UUID32_FULL  = 8'h05;
  localparam logic [7:0] AD_UUID128_PART = 8'h06;
  localparam logic [7:0] AD_UUID128_FULL = 8'h07;
  localparam logic [7:0] AD_NAME_SHORT   = 8'h08;
  localparam logic [7:0] AD_NAME_FULL    = 8'h09;
  localparam logic [7:0] AD_TX_POWER     = 8'h0A;
  localparam logic [7:0] AD_SVC_DATA16   = 8'h16;
  localparam logic [7:0] AD_APPEARANCE   = 8'h19;
  localparam logic [7:0] AD_SVC_DATA32   = 8'h20;
  localparam logic [7:0] AD_SVC_DATA128  = 8'h21;
  localparam logic [7:0] AD_MFG_DATA     = 8'hFF;

  // Result kinds
  localparam logic [3:0] KIND_FLAGS     = 4'd0;
  localparam logic [3:0] KIND_NAME      = 4'd1;
  localparam logic [3:0] KIND_TX_POWER  = 4'd2;
  localparam logic [3:0] KIND_APPEAR    = 4'd3;
  localparam logic [3:0] KIND_UUID16    = 4'd4;
  localparam logic [3:0] KIND_UUID32    = 4'd5;
  localparam logic [3:0] KIND_UUID128   = 4'd6;
  localparam logic [3:0] KIND_MFG_ID    = 4'd7;
  localparam logic [3:0] KIND_SVC16     = 4'd8;
  localparam logic [3:0] KIND_SVC32     = 4'd9;
  localparam logic [3:0] KIND_SVC128    = 4'd10;
  localparam logic [3:0] KIND_DATA_BYTE = 4'd11;
  localparam logic [3:0] KIND_END       = 4'd12;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  byte_index;
    logic        record_last;
    logic        payload_end;
    logic        end_status;
  } res_t;

endpackage

@@ rtl/bap_if.sv @@
// Valid/ready stream interfaces of the advertising record parser.
// Input carries payload bytes, output carries parsed results; no dependencies.
interface bap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] payload_length;
  logic       first_byte;

  modport source (output valid, data_byte, payload_length, first_byte, input ready);
  modport sink   (input valid, data_byte, payload_length, first_byte, output ready);
endinterface

interface bap_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [63:0] value_low;
  logic [63:0] value_high;
  logic [7:0]  byte_index;
  logic        record_last;
  logic        payload_end;
  logic        end_status;

  modport source (output valid, kind, value_low, value_high, byte_index, record_last,
                  payload_end, end_status, input ready);
  modport sink   (input valid, kind, value_low, value_high, byte_index, record_last,
                  payload_end, end_status, output ready);
endinterface

@@ rtl/bap_core.sv @@
// Record parser state and per-byte decode: one accepted byte per cycle.
// Depends on bap_pkg.
module bap_core
  import bap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] payload_length_i,
  input  logic       first_byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [4:0] {
    PH_LEN  = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_DATA = 5'b00100,
    PH_STOP = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d, phase_e_c;
  logic [7:0]  pos_q, pos_d, pos_c;
  logic [7:0]  rtype_q, rtype_d, rtype_c;
  logic [7:0]  cnt_q, cnt_d, cnt_c;
  logic [7:0]  ofs_q, ofs_d, ofs_c;
  logic [7:0]  name_len_q, name_len_d, name_len_c;
  logic        name_rep_q, name_rep_d, name_rep_c;
  logic [63:0] asm0_q, asm0_d, asm0_c;
  logic [63:0] asm1_q, asm1_d, asm1_c;
  logic        ovr_q, ovr_d, ovr_c;

  logic        have;
  res_t        res;
  logic        is_data_rec;
  logic [4:0]  id_len;
  logic [3:0]  id_kind;
  logic [7:0]  b;
  logic [8:0]  p9, len9, i9;

  always_comb begin
    // a first byte clears everything before it is parsed
    pos_c      = first_byte_i ? 8'd0   : pos_q;
    phase_e_c  = first_byte_i ? PH_LEN : phase_q;
    rtype_c    = first_byte_i ? 8'd0   : rtype_q;
    cnt_c      = first_byte_i ? 8'd0   : cnt_q;
    ofs_c      = first_byte_i ? 8'd0   : ofs_q;
    name_len_c = first_byte_i ? 8'd0   : name_len_q;
    name_rep_c = first_byte_i ? 1'b0   : name_rep_q;
    asm0_c     = first_byte_i ? 64'd0  : asm0_q;
    asm1_c     = first_byte_i ? 64'd0  : asm1_q;
    ovr_c      = first_byte_i ? 1'b0   : ovr_q;

    b    = data_byte_i;
    p9   = {1'b0, pos_c};
    len9 = {1'b0, payload_length_i};
    i9   = {1'b0, ofs_c};

    pos_d      = valid_i ? pos_c      : pos_q;
    phase_d    = valid_i ? phase_e_c  : phase_q;
    rtype_d    = valid_i ? rtype_c    : rtype_q;
    cnt_d      = valid_i ? cnt_c      : cnt_q;
    ofs_d      = valid_i ? ofs_c      : ofs_q;
    name_len_d = valid_i ? name_len_c : name_len_q;
    name_rep_d = valid_i ? name_rep_c : name_rep_q;
    asm0_d     = valid_i ? asm0_c     : asm0_q;
    asm1_d     = valid_i ? asm1_c     : asm1_q;
    ovr_d      = valid_i ? ovr_c      : ovr_q;

    have        = 1'b0;
    res         = '0;
    is_data_rec = 1'b0;
    id_len      = 5'd0;
    id_kind     = KIND_END;

    if (valid_i && phase_e_c != PH_DONE) begin
      if (p9 >= len9) begin
        phase_d = PH_DONE;
      end else begin
        unique case (phase_e_c)
          PH_LEN: begin
            if (p9 + 9'd2 < len9) begin
              if (b != 8'd0) begin
                if ({2'b00, pos_c} + 10'd1 + {2'b00, b} > {2'b00, payload_length_i}) begin
                  ovr_d   = 1'b1;
                  phase_d = PH_STOP;
                end else begin
                  cnt_d   = b - 8'd1;
                  phase_d = PH_TYPE;
                end
              end
            end else begin
              phase_d = PH_STOP;
            end
          end
          PH_TYPE: begin
            rtype_d    = b;
            ofs_d      = 8'd0;
            asm0_d     = 64'd0;
            asm1_d     = 64'd0;
            name_rep_d = 1'b0;
            if (b == AD_NAME_SHORT || b == AD_NAME_FULL) begin
              name_rep_d = cnt_c > name_len_c;
              if (cnt_c > name_len_c) name_len_d = cnt_c;
            end
            phase_d = (cnt_c != 8'd0) ? PH_DATA : PH_LEN;
          end
          PH_DATA: begin
            // assemble the byte into the uuid/identifier window
            if (rtype_c >= AD_UUID16_PART && rtype_c <= AD_UUID32_FULL) begin
              if (ofs_c[1:0] == 2'd0) asm0_d = 64'd0;
              asm0_d = asm0_d | (64'(b) << {ofs_c[1:0], 3'b000});
            end else if (ofs_c < 8'd16) begin
              if (ofs_c[3]) asm1_d = asm1_c | (64'(b) << {ofs_c[2:0], 3'b000});
              else          asm0_d = asm0_c | (64'(b) << {ofs_c[2:0], 3'b000});
            end

            case (rtype_c) inside
              AD_FLAGS, AD_TX_POWER: begin
                if (ofs_c == 8'd0) begin
                  have          = 1'b1;
                  res.kind      = (rtype_c == AD_FLAGS) ? KIND_FLAGS : KIND_TX_POWER;
                  res.value_low = 64'(b);
                end
              end
              AD_NAME_SHORT, AD_NAME_FULL: begin
                if (name_rep_c) begin
                  have           = 1'b1;
                  res.kind       = KIND_NAME;
                  res.value_low  = 64'(b);
                  res.byte_index = ofs_c;
                end
              end
              AD_APPEARANCE: begin
                if (ofs_c == 8'd1) begin
                  have          = 1'b1;
                  res.kind      = KIND_APPEAR;
                  res.value_low = {48'd0, asm0_d[15:0]};
                end
              end
              AD_UUID16_PART, AD_UUID16_FULL: begin
                if (ofs_c[0]) begin
                  have          = 1'b1;
                  res.kind      = KIND_UUID16;
                  res.value_low = ofs_c[1] ? {48'd0, asm0_d[31:16]} : {48'd0, asm0_d[15:0]};
                end
              end
              AD_UUID32_PART, AD_UUID32_FULL: begin
                if (ofs_c[1:0] == 2'd3) begin
                  have          = 1'b1;
                  res.kind      = KIND_UUID32;
                  res.value_low = {32'd0, asm0_d[31:0]};
                end
              end
              AD_UUID128_PART, AD_UUID128_FULL: begin
                if (ofs_c == 8'd15) begin
                  have           = 1'b1;
                  res.kind       = KIND_UUID128;
                  res.value_low  = asm0_d;
                  res.value_high = asm1_d;
                end
              end
              AD_MFG_DATA: begin
                is_data_rec = 1'b1; id_len = 5'd2;  id_kind = KIND_MFG_ID;
              end
              AD_SVC_DATA16: begin
                is_data_rec = 1'b1; id_len = 5'd2;  id_kind = KIND_SVC16;
              end
              AD_SVC_DATA32: begin
                is_data_rec = 1'b1; id_len = 5'd4;  id_kind = KIND_SVC32;
              end
              AD_SVC_DATA128: begin
                is_data_rec = 1'b1; id_len = 5'd16; id_kind = KIND_SVC128;
              end
              default: ;
            endcase

            // identifier first, then every byte after it; short records drop
            if (is_data_rec && cnt_c >= {3'd0, id_len}) begin
              if (i9 + 9'd1 == {4'd0, id_len}) begin
                have             = 1'b1;
                res.kind         = id_kind;
                res.value_low    = (id_len == 5'd2) ? {48'd0, asm0_d[15:0]} :
                                   (id_len == 5'd4) ? {32'd0, asm0_d[31:0]} : asm0_d;
                res.value_high   = (id_len == 5'd16) ? asm1_d : 64'd0;
                res.record_last  = (cnt_c == {3'd0, id_len});
              end else if (ofs_c >= {3'd0, id_len}) begin
                have            = 1'b1;
                res.kind        = KIND_DATA_BYTE;
                res.value_low   = 64'(b);
                res.byte_index  = ofs_c - {3'd0, id_len};
                res.record_last = (i9 + 9'd1 == {1'b0, cnt_c});
              end
            end

            ofs_d = ofs_c + 8'd1;
            if (i9 + 9'd1 >= {1'b0, cnt_c}) phase_d = PH_LEN;
          end
          PH_STOP: ;
          default: ;
        endcase

        // the last byte always answers
        if (p9 + 9'd1 == len9) begin
          if (!have) begin
            res      = '0;
            res.kind = KIND_END;
            have     = 1'b1;
          end
          res.payload_end = 1'b1;
          res.end_status  = ovr_d;
          phase_d         = PH_DONE;
        end
        pos_d = (pos_c != 8'hFF) ? pos_c + 8'd1 : 8'hFF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEN;
      pos_q      <= 8'd0;
      rtype_q    <= 8'd0;
      cnt_q      <= 8'd0;
      ofs_q      <= 8'd0;
      name_len_q <= 8'd0;
      name_rep_q <= 1'b0;
      asm0_q     <= 64'd0;
      asm1_q     <= 64'd0;
      ovr_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rtype_q    <= rtype_d;
      cnt_q      <= cnt_d;
      ofs_q      <= ofs_d;
      name_len_q <= name_len_d;
      name_rep_q <= name_rep_d;
      asm0_q     <= asm0_d;
      asm1_q     <= asm1_d;
      ovr_q      <= ovr_d;
    end
  end

  assign res_valid_o = have;
  assign res_o       = res;

`ifndef SYNTHESIS
  // a finished payload stays finished until the next first byte
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(valid_i && first_byte_i)) |=> phase_q == PH_DONE)
    else $error("parser left done without a first byte");
  // an end marker result always closes the payload
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have && res.kind == KIND_END) |-> res.payload_end)
    else $error("end-only result without payload end");
`endif

endmodule

@@ rtl/bap_res_fifo.sv @@
// Two-entry result queue between the parser core and the output channel.
// Depends on bap_pkg for the result type.
module bap_res_fifo
  import bap_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output res_t pop_data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop)      count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("result pushed into a full queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ rtl/ble_adv_record_parser.sv @@
// Top level of the advertising record parser: core plus result queue.
// Depends on bap_pkg, bap_if.sv, bap_core and bap_res_fifo.
//
// Usage:
//   in_i carries one payload byte per transaction together with the payload
//   length and a first-byte mark; a transaction with first_byte set restarts
//   the parser on a new payload. out_o carries at most one result per input
//   byte: flags, name bytes, tx power, appearance, service uuids,
//   manufacturer/service data identifiers and their data bytes. The payload's
//   last byte always yields a result with payload_end set.
//   A result is registered in the result queue as its byte is accepted and
//   is offered on out_o from the queue head. Throughput: one byte per cycle
//   while the queue has room; the decode into the queue is combinational.
//   A two-entry result queue lets the input keep flowing while one result
//   waits; in_i.ready drops only when both entries are full, so a stalled
//   receiver stops input after at most two pending results. Bytes that would
//   give no result are refused too while the queue is full: ready is simply
//   the queue not being full.
//   Reset (rst_ni low, asynchronous) empties the queue and puts the parser in
//   front of a new record length with all record state cleared.
module ble_adv_record_parser
  import bap_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bap_in_if.sink    in_i,
  bap_out_if.source out_o
);

  logic accept;
  logic res_valid;
  logic fifo_full;
  res_t res;
  res_t head;

  // accept whenever the queue has room for a possible result
  assign in_i.ready = !fifo_full;
  assign accept     = in_i.valid && !fifo_full;

  bap_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (accept),
    .data_byte_i      (in_i.data_byte),
    .payload_length_i (in_i.payload_length),
    .first_byte_i     (in_i.first_byte),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  bap_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (fifo_full),
    .pop_valid_o (out_o.valid),
    .pop_ready_i (out_o.ready),
    .pop_data_o  (head)
  );

  // drive the output payload from the queue head
  assign out_o.kind        = head.kind;
  assign out_o.value_low   = head.value_low;
  assign out_o.value_high  = head.value_high;
  assign out_o.byte_index  = head.byte_index;
  assign out_o.record_last = head.record_last;
  assign out_o.payload_end = head.payload_end;
  assign out_o.end_status  = head.end_status;

endmodule
